// ----- rtl/rlps_pkg.sv -----
// Shared types, constants and helpers for the RGB LED pulse serializer.
package rlps_pkg;

  localparam int unsigned WORD_BITS = 24;
  localparam int unsigned DUR_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned SEG_BITS = 6;

  // Reset gap is segment 0, then two segments per bit.
  localparam logic [SEG_BITS-1:0] SEG_FIRST_BIT = SEG_BITS'(1);
  localparam logic [SEG_BITS-1:0] SEG_LAST      = SEG_BITS'(2 * WORD_BITS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RESET_LOW = 3'd4;

  localparam logic [DUR_BITS-1:0] ZERO_HIGH_RST = 16'd18;
  localparam logic [DUR_BITS-1:0] ZERO_LOW_RST  = 16'd40;
  localparam logic [DUR_BITS-1:0] ONE_HIGH_RST  = 16'd35;
  localparam logic [DUR_BITS-1:0] ONE_LOW_RST   = 16'd30;
  localparam logic [DUR_BITS-1:0] RESET_LOW_RST = 16'd2500;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                line_level;
    logic [DUR_BITS-1:0] duration;
    logic                last;
  } seg_t;

  typedef struct packed {
    logic [DUR_BITS-1:0] zero_high;
    logic [DUR_BITS-1:0] zero_low;
    logic [DUR_BITS-1:0] one_high;
    logic [DUR_BITS-1:0] one_low;
    logic [DUR_BITS-1:0] reset_low;
  } cfg_t;

  // Head of the pixel queue as seen by the serializer.
  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] word;
  } q_head_t;

  // A zero-length segment cannot be driven; stretch it to a duration of 1.
  function automatic logic [DUR_BITS-1:0] at_least_one(input logic [DUR_BITS-1:0] v);
    logic [DUR_BITS-1:0] r;
    r = (v == '0) ? DUR_BITS'(1) : v;
    return r;
  endfunction

endpackage

// ----- rtl/rlps_front.sv -----
// Front end: accepts pixels, packs them GRB and queues them for the serializer.
module rlps_front import rlps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  pixel_t  in_pixel,
  output q_head_t head,
  input  logic    pop
);

  logic [WORD_BITS-1:0] mem_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;
  logic                 push;
  logic                 do_pop;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // green goes out first, then red, then blue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= {in_pixel.green, in_pixel.red, in_pixel.blue};
    end
  end

endmodule

// ----- rtl/rlps_back.sv -----
// Back end: walks one packed pixel through its 49 line segments.
module rlps_back import rlps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  q_head_t head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output seg_t    out_seg
);

  logic                 busy_r, busy_nxt;
  logic [SEG_BITS-1:0]  seg_r, seg_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic                 out_valid_r, out_valid_nxt;
  seg_t                 out_seg_r, out_seg_nxt;
  logic                 advance;
  logic                 cur_bit;
  logic                 is_last;

  assign advance = !out_valid_r || !out_stall;
  assign cur_bit = word_r[WORD_BITS-1];
  assign is_last = (seg_r == SEG_LAST);

  always_comb begin
    busy_nxt      = busy_r;
    seg_nxt       = seg_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt = 1'b0;
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        seg_nxt       = seg_r + SEG_BITS'(1);
        if (seg_r[0]) begin
          // odd segment: high part of the bit
          out_seg_nxt.line_level = 1'b1;
          out_seg_nxt.duration   = at_least_one(cur_bit ? cfg.one_high : cfg.zero_high);
          out_seg_nxt.last       = 1'b0;
        end else begin
          out_seg_nxt.line_level = 1'b0;
          out_seg_nxt.duration   = at_least_one(cur_bit ? cfg.one_low : cfg.zero_low);
          out_seg_nxt.last       = is_last;
          word_nxt               = {word_r[WORD_BITS-2:0], 1'b0};
          busy_nxt               = !is_last;
        end
      end else if (head.valid) begin
        pop                    = 1'b1;
        word_nxt               = head.word;
        busy_nxt               = 1'b1;
        seg_nxt                = SEG_FIRST_BIT;
        out_valid_nxt          = 1'b1;
        out_seg_nxt.line_level = 1'b0;
        out_seg_nxt.duration   = at_least_one(cfg.reset_low);
        out_seg_nxt.last       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    out_seg_r <= out_seg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_seg   = out_seg_r;

endmodule

// ----- rtl/rgb_led_pulse_serializer.sv -----
// Top level of the RGB LED pulse serializer: timing registers and the two halves.
//
// Each pixel request (red, green, blue) turns into 49 segment requests: one low
// reset gap, then the GRB word MSB first as a high and a low segment per bit,
// the last segment flagged. The serializer issues one segment per cycle while
// the sink does not stall; a two-entry pixel queue lets new pixels be taken
// while the current one is still being sent. Timing registers are sampled as
// segments are produced; a value of 0 is sent as a segment of duration 1.
module rgb_led_pulse_serializer import rlps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pixel_t                  in_pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output seg_t                    out_seg,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DUR_BITS-1:0]     cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  q_head_t head;
  logic    pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZERO_HIGH: cfg_nxt.zero_high = cfg_wdata;
        CFG_ZERO_LOW:  cfg_nxt.zero_low  = cfg_wdata;
        CFG_ONE_HIGH:  cfg_nxt.one_high  = cfg_wdata;
        CFG_ONE_LOW:   cfg_nxt.one_low   = cfg_wdata;
        CFG_RESET_LOW: cfg_nxt.reset_low = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_high <= ZERO_HIGH_RST;
      cfg_r.zero_low  <= ZERO_LOW_RST;
      cfg_r.one_high  <= ONE_HIGH_RST;
      cfg_r.one_low   <= ONE_LOW_RST;
      cfg_r.reset_low <= RESET_LOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rlps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .head     (head),
    .pop      (pop)
  );

  rlps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_seg   (out_seg)
  );

endmodule
